// ===== design/dst4_pkg.sv =====
// ----------------------------------------------------------------------------
// dst4_pkg
// Shared widths, types, weights and limits of the 4x4 integer DST block.
// ----------------------------------------------------------------------------
`default_nettype none

package dst4_pkg;

  localparam int SampleW   = 16;  // input sample
  localparam int MidW      = 21;  // pass-one value as stored
  localparam int ResW      = 25;  // final result
  localparam int SumW      = 29;  // weighted sum of four values, |sum| <= 242 * 2^20
  localparam int RndW      = SumW + 1;  // sum plus rounding offset
  localparam int ShiftW    = 5;
  localparam int FwdShiftW = 4;
  localparam int InvShiftW = 5;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int Lanes     = 4;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [MidW-1:0]    mid_t;
  typedef logic signed [ResW-1:0]    res_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic signed [RndW-1:0]    rnd_t;

  typedef mid_t     mid_vec_t [Lanes];
  typedef res_t     res_vec_t [Lanes];
  typedef res_vec_t res_blk_t [Lanes];

  localparam sum_t W29 = 29;
  localparam sum_t W55 = 55;
  localparam sum_t W74 = 74;

  localparam logic [ShiftW-1:0]    FwdPass1Shift = 5'd4;
  localparam logic [ShiftW-1:0]    InvPass1Shift = 5'd10;
  localparam logic [FwdShiftW-1:0] FwdPass1Min   = 4'd4;
  localparam logic [InvShiftW-1:0] InvPass1Min   = 5'd10;

  localparam rnd_t MidMax = 30'sd1048575;
  localparam rnd_t MidMin = -30'sd1048576;
  localparam rnd_t ResMax = 30'sd16777215;
  localparam rnd_t ResMin = -30'sd16777216;

  typedef enum logic [2:0] {
    REG_DIRECTION = 3'd0,
    REG_FWD_SHIFT = 3'd1,
    REG_INV_SHIFT = 3'd2,
    REG_CLAMP_MAX = 3'd3,
    REG_CLAMP_MIN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                  inverse;
    logic [FwdShiftW-1:0]  fwd_shift;
    logic [InvShiftW-1:0]  inv_shift;
    logic signed [ResW-1:0] clamp_max;
    logic signed [ResW-1:0] clamp_min;
  } cfg_t;

  typedef struct packed {
    logic                   inverse;
    logic                   last_pass;
    logic [ShiftW-1:0]      shift;
    logic signed [ResW-1:0] clamp_max;
    logic signed [ResW-1:0] clamp_min;
  } lane_ctl_t;

  typedef struct packed {
    logic inverse;
    logic mid_we;
    logic res_we;
  } merge_ctl_t;

endpackage

`default_nettype wire

// ===== design/dst4_row_if.sv =====
// ----------------------------------------------------------------------------
// dst4_row_if
// Input channel: one word is one row of four signed samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface dst4_row_if;
  logic             valid;
  logic             ready;
  dst4_pkg::sample_t sample_0;
  dst4_pkg::sample_t sample_1;
  dst4_pkg::sample_t sample_2;
  dst4_pkg::sample_t sample_3;

  modport source (output valid, output sample_0, output sample_1,
                  output sample_2, output sample_3, input ready);
  modport sink   (input valid, input sample_0, input sample_1,
                  input sample_2, input sample_3, output ready);
endinterface

`default_nettype wire

// ===== design/dst4_res_if.sv =====
// ----------------------------------------------------------------------------
// dst4_res_if
// Output channel: one word is one transformed row plus its last-row mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dst4_res_if;
  logic          valid;
  logic          ready;
  dst4_pkg::res_t result_0;
  dst4_pkg::res_t result_1;
  dst4_pkg::res_t result_2;
  dst4_pkg::res_t result_3;
  logic          last_row;

  modport source (output valid, output result_0, output result_1,
                  output result_2, output result_3, output last_row, input ready);
  modport sink   (input valid, input result_0, input result_1,
                  input result_2, input result_3, input last_row, output ready);
endinterface

`default_nettype wire

// ===== design/dst4_cfg.sv =====
// ----------------------------------------------------------------------------
// dst4_cfg
// APB register file: direction, shifts and inverse clamp bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dst4_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dst4_pkg::AddrW-1:0]    paddr,
  input  logic [dst4_pkg::DataW-1:0]    pwdata,
  output logic [dst4_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output dst4_pkg::cfg_t                cfg_o
);

  dst4_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[dst4_pkg::AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        dst4_pkg::REG_DIRECTION: cfg_d.inverse   = pwdata[0];
        dst4_pkg::REG_FWD_SHIFT: cfg_d.fwd_shift = pwdata[dst4_pkg::FwdShiftW-1:0];
        dst4_pkg::REG_INV_SHIFT: cfg_d.inv_shift = pwdata[dst4_pkg::InvShiftW-1:0];
        dst4_pkg::REG_CLAMP_MAX: cfg_d.clamp_max = pwdata[dst4_pkg::ResW-1:0];
        dst4_pkg::REG_CLAMP_MIN: cfg_d.clamp_min = pwdata[dst4_pkg::ResW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inverse   <= 1'b0;
      cfg_q.fwd_shift <= 4'd8;
      cfg_q.inv_shift <= 5'd20;
      cfg_q.clamp_max <= 25'sd32767;
      cfg_q.clamp_min <= -25'sd32768;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Bounds read back sign-extended.
  always_comb begin
    case (idx)
      dst4_pkg::REG_DIRECTION: prdata = {31'd0, cfg_q.inverse};
      dst4_pkg::REG_FWD_SHIFT: prdata = {28'd0, cfg_q.fwd_shift};
      dst4_pkg::REG_INV_SHIFT: prdata = {27'd0, cfg_q.inv_shift};
      dst4_pkg::REG_CLAMP_MAX: prdata = {{7{cfg_q.clamp_max[dst4_pkg::ResW-1]}}, cfg_q.clamp_max};
      dst4_pkg::REG_CLAMP_MIN: prdata = {{7{cfg_q.clamp_min[dst4_pkg::ResW-1]}}, cfg_q.clamp_min};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dst4_lane.sv =====
// ----------------------------------------------------------------------------
// dst4_lane
// One 4-point DST lane: weighted sums in the first stage, rounding shift,
// inverse clamp and saturation in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module dst4_lane (
  input  logic                clk_i,
  input  dst4_pkg::lane_ctl_t ctl_i,
  input  dst4_pkg::mid_vec_t  v_i,
  output dst4_pkg::res_vec_t  y_o
);

  dst4_pkg::sum_t      x [dst4_pkg::Lanes];
  dst4_pkg::sum_t      a0, a1, a2, a3, b0, b1, b2, b3;
  dst4_pkg::sum_t      sum_d [dst4_pkg::Lanes];
  dst4_pkg::sum_t      sum_q [dst4_pkg::Lanes];
  dst4_pkg::lane_ctl_t ctl_q;

  dst4_pkg::rnd_t rnd, cmax, cmin, hi, lo;
  dst4_pkg::rnd_t shv  [dst4_pkg::Lanes];
  dst4_pkg::rnd_t clv  [dst4_pkg::Lanes];
  dst4_pkg::rnd_t satv [dst4_pkg::Lanes];

  // Stage one: weighted sums.
  always_comb begin
    for (int k = 0; k < dst4_pkg::Lanes; k++) begin
      x[k] = dst4_pkg::sum_t'(v_i[k]);
    end
    a0 = x[0] + x[3];
    a1 = x[1] + x[3];
    a2 = x[0] - x[1];
    a3 = dst4_pkg::W74 * x[2];
    b0 = x[0] + x[2];
    b1 = x[2] + x[3];
    b2 = x[0] - x[3];
    b3 = dst4_pkg::W74 * x[1];
    if (ctl_i.inverse) begin
      sum_d[0] = dst4_pkg::W29 * b0 + dst4_pkg::W55 * b1 + b3;
      sum_d[1] = dst4_pkg::W55 * b2 - dst4_pkg::W29 * b1 + b3;
      sum_d[2] = dst4_pkg::W74 * (x[0] - x[2] + x[3]);
      sum_d[3] = dst4_pkg::W55 * b0 + dst4_pkg::W29 * b2 - b3;
    end else begin
      sum_d[0] = dst4_pkg::W29 * a0 + dst4_pkg::W55 * a1 + a3;
      sum_d[1] = dst4_pkg::W74 * (x[0] + x[1] - x[3]);
      sum_d[2] = dst4_pkg::W29 * a2 + dst4_pkg::W55 * a0 - a3;
      sum_d[3] = dst4_pkg::W55 * a2 - dst4_pkg::W29 * a1 + a3;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ctl_q <= ctl_i;
  end

  // Stage two: round half up, floor shift, clamp, saturate.
  always_comb begin
    rnd  = (ctl_q.shift == '0) ? '0
         : (dst4_pkg::rnd_t'(1) << (ctl_q.shift - dst4_pkg::ShiftW'(1)));
    cmax = dst4_pkg::rnd_t'($signed(ctl_q.clamp_max));
    cmin = dst4_pkg::rnd_t'($signed(ctl_q.clamp_min));
    hi   = ctl_q.last_pass ? dst4_pkg::ResMax : dst4_pkg::MidMax;
    lo   = ctl_q.last_pass ? dst4_pkg::ResMin : dst4_pkg::MidMin;
    for (int k = 0; k < dst4_pkg::Lanes; k++) begin
      shv[k] = (dst4_pkg::rnd_t'(sum_q[k]) + rnd) >>> ctl_q.shift;
      clv[k] = shv[k];
      if (ctl_q.inverse) begin
        if (shv[k] >= cmax) begin
          clv[k] = cmax;
        end else if (shv[k] <= cmin) begin
          clv[k] = cmin;
        end
      end
      if (clv[k] > hi) begin
        satv[k] = hi;
      end else if (clv[k] < lo) begin
        satv[k] = lo;
      end else begin
        satv[k] = clv[k];
      end
      y_o[k] = satv[k][dst4_pkg::ResW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/dst4_merge.sv =====
// ----------------------------------------------------------------------------
// dst4_merge
// Merge the four lane outputs into the pass-one and result stores, with the
// transposition the direction calls for, and serve pass-two operands and
// output rows.
// ----------------------------------------------------------------------------
`default_nettype none

module dst4_merge (
  input  logic                 clk_i,
  input  dst4_pkg::merge_ctl_t ctl_i,
  input  dst4_pkg::res_blk_t   y_i,
  input  logic [1:0]           row_i,
  output dst4_pkg::mid_vec_t   op_o [dst4_pkg::Lanes],
  output dst4_pkg::res_vec_t   row_o
);

  dst4_pkg::mid_t mid_q [16];
  dst4_pkg::res_t res_q [16];

  // Forward writes lane r's outputs down column r; inverse writes row r.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < dst4_pkg::Lanes; r++) begin
      for (int k = 0; k < dst4_pkg::Lanes; k++) begin
        if (ctl_i.mid_we) begin
          if (ctl_i.inverse) begin
            mid_q[4'(r * 4 + k)] <= y_i[r][k][dst4_pkg::MidW-1:0];
          end else begin
            mid_q[4'(k * 4 + r)] <= y_i[r][k][dst4_pkg::MidW-1:0];
          end
        end
        if (ctl_i.res_we) begin
          if (ctl_i.inverse) begin
            res_q[4'(r * 4 + k)] <= y_i[r][k];
          end else begin
            res_q[4'(k * 4 + r)] <= y_i[r][k];
          end
        end
      end
    end
  end

  // Forward pass two reads rows, inverse reads columns.
  always_comb begin
    for (int r = 0; r < dst4_pkg::Lanes; r++) begin
      for (int k = 0; k < dst4_pkg::Lanes; k++) begin
        op_o[r][k] = ctl_i.inverse ? mid_q[4'(k * 4 + r)] : mid_q[4'(r * 4 + k)];
      end
    end
    for (int k = 0; k < dst4_pkg::Lanes; k++) begin
      row_o[k] = res_q[{row_i, 2'(k)}];
    end
  end

endmodule

`default_nettype wire

// ===== design/dst4x4_transform.sv =====
// ----------------------------------------------------------------------------
// dst4x4_transform
// Two-pass 4x4 integer DST (weights 29, 55, 74), forward or inverse.
//
// Usage: send one block as four words on row_i, one row of four signed
// 16-bit samples each. After the fourth word the block is transformed and
// four result words leave on res_o, row 0 first; last_row marks the fourth.
// Settings come from the APB port (direction, forward and inverse shifts,
// inverse clamp bounds); write them only while no block is in flight.
// Timing: four parallel lanes run pass one as a sum step, then a round and
// clamp step, and pass two the same way; the first result word is valid
// once S_P1_SUM, S_P1_RND, S_P2_SUM and S_P2_RND have run in turn after the
// fourth input word is taken, and the four result words then leave one per
// cycle while res_o.ready stays high.
// Overlap: rows 0..2 of the next block are taken while a block computes
// or drains, but its fourth row waits until the result store is free; the
// shared result store and the two-pass lane sequence set this limit.
// A receiver stall holds the current result word on res_o unchanged.
// Reset clears the row and output counters, returns the sequencer to idle
// and loads the register defaults; sample and result stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dst4x4_transform (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dst4_row_if.sink                   row_i,
  dst4_res_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dst4_pkg::AddrW-1:0] paddr,
  input  logic [dst4_pkg::DataW-1:0] pwdata,
  output logic [dst4_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_P1_SUM = 6'b000010,
    S_P1_RND = 6'b000100,
    S_P2_SUM = 6'b001000,
    S_P2_RND = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] row_cnt_q, row_cnt_d;
  logic [1:0] out_row_q, out_row_d;

  dst4_pkg::cfg_t       cfg;
  dst4_pkg::sample_t    in_blk_q [16];
  dst4_pkg::sample_t    smp [dst4_pkg::Lanes];
  dst4_pkg::mid_vec_t   op   [dst4_pkg::Lanes];
  dst4_pkg::mid_vec_t   op_p2 [dst4_pkg::Lanes];
  dst4_pkg::res_blk_t   lane_y;
  dst4_pkg::res_vec_t   res_row;
  dst4_pkg::lane_ctl_t  lane_ctl;
  dst4_pkg::merge_ctl_t merge_ctl;
  logic [dst4_pkg::ShiftW-1:0] shift2;

  logic in_fire, out_fire, block_done;

  dst4_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input side: the fourth row may only enter when the sequencer is idle.
  assign row_i.ready = (row_cnt_q != 2'd3) || (state_q == S_IDLE);
  assign in_fire     = row_i.valid && row_i.ready;
  assign block_done  = in_fire && (row_cnt_q == 2'd3);
  assign row_cnt_d   = in_fire ? row_cnt_q + 2'd1 : row_cnt_q;

  assign smp[0] = row_i.sample_0;
  assign smp[1] = row_i.sample_1;
  assign smp[2] = row_i.sample_2;
  assign smp[3] = row_i.sample_3;

  // Hold the block; row_cnt_q picks the row being filled.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < dst4_pkg::Lanes; k++) begin
        in_blk_q[{row_cnt_q, 2'(k)}] <= smp[k];
      end
    end
  end

  // Second-pass shift, floored at zero when the total is short.
  always_comb begin
    if (cfg.inverse) begin
      shift2 = (cfg.inv_shift < dst4_pkg::InvPass1Min) ? '0
             : cfg.inv_shift - dst4_pkg::InvPass1Min;
    end else begin
      shift2 = (cfg.fwd_shift < dst4_pkg::FwdPass1Min) ? '0
             : dst4_pkg::ShiftW'(cfg.fwd_shift - dst4_pkg::FwdPass1Min);
    end
  end

  // Lane operands: pass one reads the input block (forward by row,
  // inverse by column); pass two reads the pass-one store via the merge.
  always_comb begin
    lane_ctl.inverse   = cfg.inverse;
    lane_ctl.clamp_max = cfg.clamp_max;
    lane_ctl.clamp_min = cfg.clamp_min;
    if (state_q == S_P1_SUM) begin
      lane_ctl.last_pass = 1'b0;
      lane_ctl.shift     = cfg.inverse ? dst4_pkg::InvPass1Shift : dst4_pkg::FwdPass1Shift;
    end else begin
      lane_ctl.last_pass = 1'b1;
      lane_ctl.shift     = shift2;
    end
    for (int r = 0; r < dst4_pkg::Lanes; r++) begin
      for (int k = 0; k < dst4_pkg::Lanes; k++) begin
        if (state_q == S_P1_SUM) begin
          op[r][k] = cfg.inverse ? dst4_pkg::mid_t'(in_blk_q[4'(k * 4 + r)])
                                 : dst4_pkg::mid_t'(in_blk_q[4'(r * 4 + k)]);
        end else begin
          op[r][k] = op_p2[r][k];
        end
      end
    end
  end

  for (genvar g = 0; g < dst4_pkg::Lanes; g++) begin : g_lane
    dst4_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .v_i   (op[g]),
      .y_o   (lane_y[g])
    );
  end

  assign merge_ctl.inverse = cfg.inverse;
  assign merge_ctl.mid_we  = (state_q == S_P1_RND);
  assign merge_ctl.res_we  = (state_q == S_P2_RND);

  dst4_merge u_merge (
    .clk_i (clk_i),
    .ctl_i (merge_ctl),
    .y_i   (lane_y),
    .row_i (out_row_q),
    .op_o  (op_p2),
    .row_o (res_row)
  );

  // Output side: drive rows from the result store.
  assign res_o.valid    = (state_q == S_OUT);
  assign res_o.result_0 = res_row[0];
  assign res_o.result_1 = res_row[1];
  assign res_o.result_2 = res_row[2];
  assign res_o.result_3 = res_row[3];
  assign res_o.last_row = (out_row_q == 2'd3);
  assign out_fire       = res_o.valid && res_o.ready;
  assign out_row_d      = out_fire ? out_row_q + 2'd1 : out_row_q;

  // Sequencer: a sum state and a round state per pass, then drain.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (block_done) state_d = S_P1_SUM;
      S_P1_SUM: state_d = S_P1_RND;
      S_P1_RND: state_d = S_P2_SUM;
      S_P2_SUM: state_d = S_P2_RND;
      S_P2_RND: state_d = S_OUT;
      S_OUT:    if (out_fire && (out_row_q == 2'd3)) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_cnt_q <= 2'd0;
      out_row_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

`default_nettype wire
